[hdl/strip_fan_triangle_assembler_assert.svh]
// Assertion macros for the strip/fan triangle assembler RTL.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFTA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SFTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/sfta_pkg.sv]
// Types and constants of the strip/fan triangle assembler.
package sfta_pkg;

  localparam int FieldW  = 16;
  localparam int CornerW = 16;
  localparam int TotalW  = 17;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_COMMAND = 2'd1,
    OP_VERTEX  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_VERT = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_TRIANGLE        = 3'd0,
    ST_MESH_OK         = 3'd1,
    ST_BAD_COMMAND     = 3'd2,
    ST_BAD_INDEX       = 3'd3,
    ST_VERTEX_OVERFLOW = 3'd4,
    ST_COUNT_MISMATCH  = 3'd5,
    ST_OUT_OF_ORDER    = 3'd6
  } status_e;

  // Configuration register indexes
  localparam logic CfgVertexTableSize = 1'b0;
  localparam logic CfgNormalTableSize = 1'b1;

  typedef struct packed {
    logic [TotalW-1:0]  vertex_total;
    logic [CornerW-1:0] corner_c;
    logic [CornerW-1:0] corner_b;
    logic [CornerW-1:0] corner_a;
    status_e            status;
  } result_t;

endpackage

[hdl/sfta_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
`include "strip_fan_triangle_assembler_assert.svh"

module sfta_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfta_pkg::result_t push_data_i,
  output logic             room_o,
  output logic             out_valid_o,
  output sfta_pkg::result_t out_data_o,
  input  logic             out_ready_i
);
  import sfta_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop         = out_valid_q & out_ready_i;
  assign room_o      = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Load the skid entry or a new push into the output register when the head is empty or drains
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `SFTA_ASSERT_SAME(a_skid_behind_head, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `SFTA_ASSERT_SAME(a_no_push_when_full, clk_i, rst_ni, push_i, !skid_valid_q)
  `SFTA_ASSERT_NEXT(a_head_holds, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q))

endmodule

[hdl/strip_fan_triangle_assembler.sv]
// A result enters the output register, or the skid register if the head is waiting.
// Throughput: one input beat per cycle while s_axis_tready is high; state update
// and checks are single-pass logic. A two-entry output buffer keeps input flowing
// while a result waits; s_axis_tready drops only when both entries are full.
// Reset (rst_ni low, asynchronous): idle awaiting start, table sizes zero, buffer empty.
module strip_fan_triangle_assembler #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] triangle_budget, [31:16] command_word, [47:32] position idx,
  // [63:48] normal idx
  input  logic [63:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] corner_a, [31:16] corner_b, [47:32] corner_c, [64:48] vertex_total,
  // [71:65] zero
  output logic [71:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sfta_pkg::*;

  localparam int CntW        = INDEX_BITS + 1;
  localparam int CornerWideW = (INDEX_BITS > CornerW) ? INDEX_BITS : CornerW;
  localparam int TotalWideW  = (CntW > TotalW) ? CntW : TotalW;

  // configuration registers
  logic [FieldW-1:0] vtx_size_q, nrm_size_q;

  // mesh state
  phase_e                phase_q, phase_d;
  logic                  fan_mode_q, fan_mode_d;
  logic [14:0]           vertices_left_q, vertices_left_d;
  logic [14:0]           strip_pos_q, strip_pos_d;
  logic [INDEX_BITS-1:0] first_corner_q, first_corner_d;
  logic [INDEX_BITS-1:0] older_corner_q, older_corner_d;
  logic [INDEX_BITS-1:0] prior_corner_q, prior_corner_d;
  logic [CntW-1:0]       next_canon_q, next_canon_d;
  logic [FieldW-1:0]     tris_left_q, tris_left_d;

  // input fields
  opcode_e           opcode;
  logic [FieldW-1:0] budget, cmd_word, vtx_idx, nrm_idx;
  logic [FieldW-1:0] mag, mag_m2;
  logic [INDEX_BITS-1:0] cur, tri_a, tri_b;
  logic [CornerWideW-1:0] a_wide, b_wide, c_wide;
  logic [TotalWideW-1:0]  total_wide;

  logic    accept, has_result;
  result_t res;
  result_t out_data;
  logic    buf_room;

  assign opcode   = opcode_e'(s_axis_tuser);
  assign budget   = s_axis_tdata[15:0];
  assign cmd_word = s_axis_tdata[31:16];
  assign vtx_idx  = s_axis_tdata[47:32];
  assign nrm_idx  = s_axis_tdata[63:48];

  assign s_axis_tready = buf_room;
  assign accept        = s_axis_tvalid & buf_room;
  assign cfg_ready_o   = 1'b1;

  // magnitude of the signed vertex count
  assign mag    = cmd_word[FieldW-1] ? FieldW'(-cmd_word) : cmd_word;
  assign mag_m2 = mag - FieldW'(2);
  assign cur    = next_canon_q[INDEX_BITS-1:0];

  // corner selection: fans pivot on the first vertex, strips alternate winding
  always_comb begin
    if (fan_mode_q) begin
      tri_a = first_corner_q;
      tri_b = prior_corner_q;
    end else if (strip_pos_q[0]) begin
      tri_a = prior_corner_q;
      tri_b = older_corner_q;
    end else begin
      tri_a = older_corner_q;
      tri_b = prior_corner_q;
    end
  end

  assign a_wide     = CornerWideW'(tri_a);
  assign b_wide     = CornerWideW'(tri_b);
  assign c_wide     = CornerWideW'(cur);
  assign total_wide = TotalWideW'(next_canon_q);

  // decode the beat, update mesh state and form the result
  always_comb begin
    phase_d         = phase_q;
    fan_mode_d      = fan_mode_q;
    vertices_left_d = vertices_left_q;
    strip_pos_d     = strip_pos_q;
    first_corner_d  = first_corner_q;
    older_corner_d  = older_corner_q;
    prior_corner_d  = prior_corner_q;
    next_canon_d    = next_canon_q;
    tris_left_d     = tris_left_q;
    has_result      = 1'b0;
    res             = '0;
    if (accept) begin
      unique case (opcode)
        OP_START: begin
          phase_d         = PH_CMD;
          fan_mode_d      = 1'b0;
          vertices_left_d = '0;
          strip_pos_d     = '0;
          first_corner_d  = '0;
          older_corner_d  = '0;
          prior_corner_d  = '0;
          next_canon_d    = '0;
          tris_left_d     = budget;
        end
        OP_COMMAND: begin
          if (phase_q != PH_ERR) begin
            has_result = 1'b1;
            if (phase_q != PH_CMD) begin
              phase_d    = PH_ERR;
              res.status = ST_OUT_OF_ORDER;
            end else if (cmd_word == '0) begin
              if (tris_left_q != '0) begin
                phase_d    = PH_ERR;
                res.status = ST_COUNT_MISMATCH;
              end else begin
                phase_d          = PH_IDLE;
                res.status       = ST_MESH_OK;
                res.vertex_total = total_wide[TotalW-1:0];
              end
            end else if (mag < FieldW'(3) || mag_m2 > tris_left_q) begin
              phase_d    = PH_ERR;
              res.status = ST_BAD_COMMAND;
            end else begin
              has_result      = 1'b0;
              tris_left_d     = tris_left_q - mag_m2;
              fan_mode_d      = cmd_word[FieldW-1];
              vertices_left_d = 15'(mag - FieldW'(1));
              strip_pos_d     = '0;
              phase_d         = PH_VERT;
            end
          end
        end
        OP_VERTEX: begin
          if (phase_q != PH_ERR) begin
            has_result = 1'b1;
            if (phase_q != PH_VERT) begin
              phase_d    = PH_ERR;
              res.status = ST_OUT_OF_ORDER;
            end else if (vtx_idx[FieldW-1] || vtx_idx >= vtx_size_q ||
                         nrm_idx[FieldW-1] || nrm_idx >= nrm_size_q) begin
              phase_d    = PH_ERR;
              res.status = ST_BAD_INDEX;
            end else if (next_canon_q[INDEX_BITS]) begin
              phase_d    = PH_ERR;
              res.status = ST_VERTEX_OVERFLOW;
            end else begin
              // triangle from the third vertex of the command onward
              has_result     = (strip_pos_q >= 15'd2);
              res.status     = ST_TRIANGLE;
              res.corner_a   = a_wide[CornerW-1:0];
              res.corner_b   = b_wide[CornerW-1:0];
              res.corner_c   = c_wide[CornerW-1:0];
              next_canon_d   = next_canon_q + CntW'(1);
              if (strip_pos_q == '0) begin
                first_corner_d = cur;
              end
              older_corner_d = prior_corner_q;
              prior_corner_d = cur;
              if (strip_pos_q != 15'h7FFF) begin
                strip_pos_d = strip_pos_q + 15'd1;
              end
              if (vertices_left_q == '0) begin
                phase_d = PH_CMD;
              end else begin
                vertices_left_d = vertices_left_q - 15'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      fan_mode_q      <= 1'b0;
      vertices_left_q <= '0;
      strip_pos_q     <= '0;
      first_corner_q  <= '0;
      older_corner_q  <= '0;
      prior_corner_q  <= '0;
      next_canon_q    <= '0;
      tris_left_q     <= '0;
    end else begin
      phase_q         <= phase_d;
      fan_mode_q      <= fan_mode_d;
      vertices_left_q <= vertices_left_d;
      strip_pos_q     <= strip_pos_d;
      first_corner_q  <= first_corner_d;
      older_corner_q  <= older_corner_d;
      prior_corner_q  <= prior_corner_d;
      next_canon_q    <= next_canon_d;
      tris_left_q     <= tris_left_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_size_q <= '0;
      nrm_size_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgVertexTableSize) begin
        vtx_size_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgNormalTableSize) begin
        nrm_size_q <= cfg_data_i;
      end
    end
  end

  // result register and skid stage
  sfta_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (has_result),
    .push_data_i (res),
    .room_o      (buf_room),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_data.vertex_total, out_data.corner_c,
                         out_data.corner_b, out_data.corner_a};
  assign m_axis_tuser = out_data.status;

endmodule

[verif/strip_fan_triangle_assembler_test.sv]
// Self-checking testbench for the strip/fan triangle assembler: directed and random streams.
module strip_fan_triangle_assembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfta_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned IndexBits  = 16;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned PrintLimit = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  strip_fan_triangle_assembler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the assembler state and its table sizes
  phase_e      mesh_phase = PH_IDLE;
  bit          fan_mode = 1'b0;
  int unsigned vertices_left = 0;
  int unsigned strip_pos = 0;
  int unsigned first_corner = 0;
  int unsigned older_corner = 0;
  int unsigned prior_corner = 0;
  int unsigned next_canonical = 0;
  int unsigned triangles_left = 0;
  logic [15:0] vertex_limit = '0;
  logic [15:0] normal_limit = '0;

  result_t     due_primitives[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  logic [15:0] ready_pattern = '1;
  int unsigned pattern_age = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic void post_result(status_e st, int unsigned a, int unsigned b,
                                      int unsigned c, int unsigned total);
    result_t r;
    r.status       = st;
    r.corner_a     = a[15:0];
    r.corner_b     = b[15:0];
    r.corner_c     = c[15:0];
    r.vertex_total = total[16:0];
    due_primitives = {due_primitives, r};
  endfunction

  function automatic void latch_error(status_e st);
    mesh_phase = PH_ERR;
    post_result(st, 0, 0, 0, 0);
  endfunction

  // Advance the mirrored state by one accepted beat and queue its triangle or status
  function automatic void assemble_primitive(opcode_e op, logic [15:0] budget,
                                             logic [15:0] cmd, logic [15:0] vidx,
                                             logic [15:0] nidx);
    int          count;
    int          vi;
    int          ni;
    int unsigned mag;
    int unsigned cur;
    int unsigned pos;
    int unsigned ca;
    int unsigned cb;
    ca = 0;
    cb = 0;
    if (op == OP_START) begin
      mesh_phase     = PH_CMD;
      fan_mode       = 1'b0;
      vertices_left  = 0;
      strip_pos      = 0;
      first_corner   = 0;
      older_corner   = 0;
      prior_corner   = 0;
      next_canonical = 0;
      triangles_left = budget;
      return;
    end
    if (op == OP_NONE || mesh_phase == PH_ERR) return;

    if (op == OP_COMMAND) begin
      if (mesh_phase != PH_CMD) begin
        latch_error(ST_OUT_OF_ORDER);
        return;
      end
      count = $signed(cmd);
      if (count == 0) begin
        if (triangles_left != 0) begin
          latch_error(ST_COUNT_MISMATCH);
          return;
        end
        mesh_phase = PH_IDLE;
        post_result(ST_MESH_OK, 0, 0, 0, next_canonical);
        return;
      end
      mag = (count < 0) ? -count : count;
      if (mag < 3 || mag - 2 > triangles_left) begin
        latch_error(ST_BAD_COMMAND);
        return;
      end
      triangles_left -= mag - 2;
      fan_mode       = count < 0;
      vertices_left  = mag - 1;
      strip_pos      = 0;
      mesh_phase     = PH_VERT;
      return;
    end

    // vertex record
    if (mesh_phase != PH_VERT) begin
      latch_error(ST_OUT_OF_ORDER);
      return;
    end
    vi = $signed(vidx);
    ni = $signed(nidx);
    if (vi < 0 || vi >= int'(vertex_limit) || ni < 0 || ni >= int'(normal_limit)) begin
      latch_error(ST_BAD_INDEX);
      return;
    end
    if (next_canonical >= (1 << IndexBits)) begin
      latch_error(ST_VERTEX_OVERFLOW);
      return;
    end
    cur = next_canonical;
    next_canonical++;
    pos = strip_pos;
    if (pos >= 2) begin
      if (fan_mode) begin
        ca = first_corner;
        cb = prior_corner;
      end else if (pos[0]) begin
        ca = prior_corner;
        cb = older_corner;
      end else begin
        ca = older_corner;
        cb = prior_corner;
      end
    end
    if (pos == 0) first_corner = cur;
    older_corner = prior_corner;
    prior_corner = cur;
    if (strip_pos < 'h7FFF) strip_pos++;
    if (vertices_left == 0) mesh_phase = PH_CMD;
    else vertices_left--;
    if (pos >= 2) post_result(ST_TRIANGLE, ca, cb, cur, 0);
  endfunction

  // Check result beats, then track config writes and input beats
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_primitives.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat, status %0d", m_axis_tuser));
        end else begin
          want = due_primitives.pop_front();
          check_field("status", m_axis_tuser, want.status);
          check_field("corner_a", m_axis_tdata[15:0], want.corner_a);
          check_field("corner_b", m_axis_tdata[31:16], want.corner_b);
          check_field("corner_c", m_axis_tdata[47:32], want.corner_c);
          check_field("vertex_total", m_axis_tdata[64:48], want.vertex_total);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgVertexTableSize) vertex_limit = cfg_data_i;
        else normal_limit = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        assemble_primitive(opcode_e'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16],
                           s_axis_tdata[47:32], s_axis_tdata[63:48]);
      end
    end
  end

  // Stall the result side on a rotating pattern, reloaded now and then
  always @(negedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom);
        2:       ready_pattern = 16'($urandom) | 16'($urandom);
        default: ready_pattern = 16'h0101;
      endcase
      pattern_age = $urandom_range(8, 64);
    end
    pattern_age--;
    m_axis_tready = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Drive one beat, in bursts with random gaps, and hold it until accepted
  task automatic send_item(opcode_e op, logic [15:0] budget, logic [15:0] cmd,
                           logic [15:0] vidx, logic [15:0] nidx);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {nidx, vidx, cmd, budget};
    if (op != OP_NONE) items_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_start(logic [15:0] budget);
    send_item(OP_START, budget, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_command(int count);
    send_item(OP_COMMAND, 16'($urandom), 16'(count), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_vertex(logic [15:0] vidx, logic [15:0] nidx);
    send_item(OP_VERTEX, 16'($urandom), 16'($urandom), vidx, nidx);
  endtask

  function automatic logic [15:0] pick_index(int unsigned size);
    return (size == 0) ? 16'd0 : 16'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [15:0] pick_bad_index(int unsigned size);
    case ($urandom_range(0, 2))
      0:       return 16'h8000 | 16'($urandom);
      1:       return (size < 32768) ? 16'(size) : 16'hFFFF;
      default: return (size < 32768) ? 16'($urandom_range(size, 32767)) : 16'h8000;
    endcase
  endfunction

  // One command and all of its records, with valid indices
  task automatic send_run(int count, int unsigned vsize, int unsigned nsize);
    send_command(count);
    repeat ((count < 0) ? -count : count) send_vertex(pick_index(vsize), pick_index(nsize));
  endtask

  // Drop valid, wait out every expected result, then let the pipe empty
  task automatic settle_outputs();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (due_primitives.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (due_primitives.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", due_primitives.size()));
      due_primitives.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_table_size(logic index, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_tables(int unsigned vsize, int unsigned nsize);
    settle_outputs();
    write_table_size(CfgVertexTableSize, 16'(vsize));
    write_table_size(CfgNormalTableSize, 16'(nsize));
  endtask

  // Tables still zero: idle-phase record, empty mesh, any record is a bad index
  task automatic test_idle_reset_state();
    send_vertex(16'd0, 16'd0);
    send_start(16'd0);
    send_command(0);
    send_start(16'd1);
    send_run(3, 0, 0);
  endtask

  // Strip winding alternates, fan corners pivot on the first vertex
  task automatic test_strip_and_fan_winding();
    set_tables(32768, 32768);
    send_start(16'd4);
    send_command(4);
    send_vertex(16'd0, 16'd0);
    send_vertex(16'd32767, 16'd32767);
    send_vertex(16'h5555, 16'h2AAA);
    send_vertex(16'h2AAA, 16'h5555);
    send_run(-4, 32768, 32768);
    send_command(0);
  endtask

  // Error statuses other than vertex overflow, latching, ignored opcode
  task automatic test_malformed_streams();
    send_command(3);
    send_start(16'd3);
    send_command(2);
    send_command(0);
    send_start(16'd1);
    send_command(-32768);
    send_start(16'hFFFF);
    send_command(-3);
    send_vertex(16'h8000, 16'd0);
    send_start(16'd1);
    send_command(3);
    send_vertex(16'd1, 16'd2);
    send_item(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_command(3);
    send_start(16'd2);
    send_command(0);
    send_start(16'd1);
    send_command(3);
    send_vertex(16'd5, 16'hFFFF);
  endtask

  // Mostly well-formed meshes with random content, some faults and some noise
  task automatic send_random_mesh(int unsigned vsize, int unsigned nsize);
    int unsigned runs;
    int unsigned sum;
    int unsigned budget;
    int unsigned fault;
    int unsigned lengths[4];
    bit          fans[4];
    int          count;
    logic [15:0] vi;
    logic [15:0] ni;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 6))
        send_item(opcode_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      return;
    end
    runs = $urandom_range(0, 4);
    sum  = 0;
    for (int i = 0; i < runs; i++) begin
      lengths[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
      fans[i]    = $urandom_range(0, 1);
      sum       += lengths[i] - 2;
    end
    case ($urandom_range(0, 9))
      0:       budget = sum + $urandom_range(1, 3);
      1:       budget = (sum > 0) ? sum - 1 : 0;
      2:       budget = $urandom_range(0, 65535);
      default: budget = sum;
    endcase
    send_start(16'(budget));
    for (int i = 0; i < runs; i++) begin
      count = fans[i] ? -int'(lengths[i]) : int'(lengths[i]);
      if ($urandom_range(0, 29) == 0) count = int'($urandom_range(0, 4)) - 2;
      send_command(count);
      for (int v = 0; v < lengths[i]; v++) begin
        fault = $urandom_range(0, 59);
        if (fault == 3) break;
        if (fault == 2)
          send_item(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (fault == 4) send_command(3);
        vi = (fault == 0) ? pick_bad_index(vsize) : pick_index(vsize);
        ni = (fault == 1) ? pick_bad_index(nsize) : pick_index(nsize);
        send_vertex(vi, ni);
      end
    end
    if ($urandom_range(0, 7) != 0) send_command(0);
  endtask

  task automatic test_random_meshes(int unsigned goal, int unsigned vsize, int unsigned nsize);
    int unsigned first;
    set_tables(vsize, nsize);
    first = items_sent;
    while (items_sent - first < goal) send_random_mesh(vsize, nsize);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_reset_state();
    test_strip_and_fan_winding();
    test_malformed_streams();
    test_random_meshes(400, 32768, 32768);
    test_random_meshes(250, 1, 1);
    test_random_meshes(350, $urandom_range(1, 32768), $urandom_range(1, 32768));
    test_random_meshes(60, 0, 32768);
    test_random_meshes(60, 32768, 0);
    test_random_meshes(200, $urandom_range(2, 9), $urandom_range(2, 9));
    settle_outputs();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
